FILE: src/pi_trapezoid_partial_sum_core_defines.svh
// assertion macros shared by the pi trapezoid partial sum rtl
`ifndef PI_TRAPEZOID_PARTIAL_SUM_CORE_DEFINES_SVH
`define PI_TRAPEZOID_PARTIAL_SUM_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PI_TPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PI_TPS_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define PI_TPS_ASSERT(lbl, prop, msg)
`define PI_TPS_NEVER(lbl, expr, msg)
`endif
`endif

FILE: src/pi_tps_pkg.sv
// types and constants of the pi trapezoid partial sum core
package pi_tps_pkg;
	localparam int FRAC_BITS  = 30;
	localparam int IDX_W      = 17;
	localparam int SUM_W      = 32;
	localparam int H_W        = FRAC_BITS + 2;
	localparam int Y_W        = FRAC_BITS + 2;
	localparam int R_W        = 2 * FRAC_BITS + 4;
	localparam int P_W        = Y_W + 1 + H_W;
	localparam int A_W        = P_W - (FRAC_BITS + 1);
	localparam int ITER_STEPS = H_W;
	localparam int CNT_W      = $clog2(ITER_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITER_STEPS - 1);
	localparam logic [R_W-1:0]   FOUR     = R_W'(1) << (2 * FRAC_BITS + 2);
	localparam logic [R_W-1:0]   ONE_INIT = R_W'(1) << (2 * FRAC_BITS + 2);
	localparam logic [H_W-1:0]   DIVIDEND = H_W'(1) << (FRAC_BITS + 1);
	localparam logic [SUM_W-1:0] SUM_MAX  = '1;

	typedef struct packed {
		logic [IDX_W-1:0] step_count;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] end_index;
	} in_t;

	typedef struct packed {
		logic [SUM_W-1:0] partial_sum;
		logic             range_error;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_XMUL, ST_SQ, ST_ROOT, ST_LEFT, ST_AREA, ST_ACC, ST_CHECK, ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic xmul;
		logic square;
		logic root_step;
		logic save_left;
		logic area;
		logic acc;
		logic idx_inc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic in_err;
		logic at_end;
	} status_t;
endpackage

FILE: src/pi_trapezoid_partial_sum_core.sv
// one transaction at a time; the next is taken once the result is registered
// the square root of each interval sets the rate, which grows with end - first
// a rejected transaction goes straight from idle to the done state and skips all computation
// arst_n clears the controller and the output valid; datapath registers are not reset
module pi_trapezoid_partial_sum_core #(
	parameter int unsigned MAX_STEPS = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pi_tps_pkg::in_t   in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pi_tps_pkg::out_t  out_data
);
	pi_tps_pkg::cmd_t    cmd;
	pi_tps_pkg::status_t status;

	pi_tps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	pi_tps_dp #(
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk      (clk),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);
endmodule

FILE: src/pi_tps_ctrl.sv
// sequencer for division, square roots and accumulation of one transaction
`include "pi_trapezoid_partial_sum_core_defines.svh"
module pi_tps_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  pi_tps_pkg::status_t status,
	output pi_tps_pkg::cmd_t    cmd
);
	pi_tps_pkg::state_t state_q, state_d;
	logic [pi_tps_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic first_q, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pi_tps_pkg::ST_IDLE;
			cnt_q       <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= cmd.out_load | (out_valid_q & ~out_ready);
			if (cmd.load) begin
				first_q <= 1'b1;
			end else if (cmd.save_left) begin
				first_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			pi_tps_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = status.in_err ? pi_tps_pkg::ST_DONE : pi_tps_pkg::ST_DIV;
				end
			end
			pi_tps_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == pi_tps_pkg::CNT_LAST) begin
					state_d = pi_tps_pkg::ST_XMUL;
				end
			end
			pi_tps_pkg::ST_XMUL: begin
				cmd.xmul = 1'b1;
				state_d  = pi_tps_pkg::ST_SQ;
			end
			pi_tps_pkg::ST_SQ: begin
				cmd.square = 1'b1;
				state_d    = pi_tps_pkg::ST_ROOT;
			end
			pi_tps_pkg::ST_ROOT: begin
				cmd.root_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == pi_tps_pkg::CNT_LAST) begin
					state_d = first_q ? pi_tps_pkg::ST_LEFT : pi_tps_pkg::ST_AREA;
				end
			end
			pi_tps_pkg::ST_LEFT: begin
				cmd.save_left = 1'b1;
				state_d       = pi_tps_pkg::ST_CHECK;
			end
			pi_tps_pkg::ST_AREA: begin
				cmd.area = 1'b1;
				state_d  = pi_tps_pkg::ST_ACC;
			end
			pi_tps_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = pi_tps_pkg::ST_CHECK;
			end
			pi_tps_pkg::ST_CHECK: begin
				if (status.at_end) begin
					state_d = pi_tps_pkg::ST_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = pi_tps_pkg::ST_XMUL;
				end
			end
			pi_tps_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = pi_tps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pi_tps_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_ready  = (state_q == pi_tps_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// a result must never overwrite one that is still waiting
	`PI_TPS_NEVER(a_no_overwrite, cmd.out_load && out_valid_q && !out_ready, "result overwritten")
	`PI_TPS_ASSERT(a_err_skips, (in_valid && in_ready && status.in_err) |=> (state_q == pi_tps_pkg::ST_DONE), "rejected transaction did work")
	`PI_TPS_ASSERT(a_root_cnt, (state_q == pi_tps_pkg::ST_SQ) |=> (cnt_q == '0), "root counter misaligned")
	`PI_TPS_ASSERT(a_left_once, cmd.area |-> !first_q, "area without left edge")
endmodule

FILE: src/pi_tps_dp.sv
// datapath: step divider, edge square root, area multiply and sum
module pi_tps_dp #(
	parameter int unsigned MAX_STEPS = 65536
) (
	input  logic                clk,
	input  pi_tps_pkg::in_t     in_data,
	input  pi_tps_pkg::cmd_t    cmd,
	output pi_tps_pkg::status_t status,
	output pi_tps_pkg::out_t    out_data
);
	logic [pi_tps_pkg::IDX_W-1:0] n_q, idx_q, end_q, rem_q;
	logic [pi_tps_pkg::H_W-1:0]   quo_q, x_q;
	logic [pi_tps_pkg::R_W-1:0]   d_q, res_q, one_q;
	logic [pi_tps_pkg::Y_W-1:0]   yl_q;
	logic [pi_tps_pkg::P_W-1:0]   prod_q;
	logic [pi_tps_pkg::SUM_W-1:0] sum_q;
	logic                         err_q;
	pi_tps_pkg::out_t             out_q;

	logic [pi_tps_pkg::IDX_W:0]     trial, trial_sub;
	logic                           ge;
	logic [pi_tps_pkg::R_W-1:0]     sq, cand;
	logic [pi_tps_pkg::Y_W-1:0]     root;
	logic [pi_tps_pkg::Y_W:0]       ysum;
	logic [pi_tps_pkg::A_W-1:0]     area;
	logic [pi_tps_pkg::A_W:0]       tot;
	logic [pi_tps_pkg::IDX_W+pi_tps_pkg::H_W-1:0] xprod;

	// restoring division of 2^(frac+1) by n, one quotient bit per cycle
	assign trial     = {rem_q, quo_q[pi_tps_pkg::H_W-1]};
	assign ge        = trial >= {1'b0, n_q};
	assign trial_sub = trial - {1'b0, n_q};

	assign xprod = {{pi_tps_pkg::H_W{1'b0}}, idx_q} * {{pi_tps_pkg::IDX_W{1'b0}}, quo_q};
	assign sq    = {{(pi_tps_pkg::R_W-pi_tps_pkg::H_W){1'b0}}, x_q}
		* {{(pi_tps_pkg::R_W-pi_tps_pkg::H_W){1'b0}}, x_q};
	assign cand  = res_q + one_q;
	assign root  = res_q[pi_tps_pkg::Y_W-1:0];
	assign ysum  = {1'b0, yl_q} + {1'b0, root};
	assign area  = prod_q[pi_tps_pkg::P_W-1:pi_tps_pkg::FRAC_BITS+1];
	assign tot   = {1'b0, area} + (pi_tps_pkg::A_W+1)'(sum_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= in_data.step_count;
			idx_q <= in_data.first_index;
			end_q <= in_data.end_index;
			err_q <= status.in_err;
			rem_q <= '0;
			quo_q <= pi_tps_pkg::DIVIDEND;
			sum_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? trial_sub[pi_tps_pkg::IDX_W-1:0] : trial[pi_tps_pkg::IDX_W-1:0];
			quo_q <= {quo_q[pi_tps_pkg::H_W-2:0], ge};
		end
		if (cmd.xmul) begin
			x_q <= xprod[pi_tps_pkg::H_W-1:0];
		end
		if (cmd.square) begin
			d_q   <= pi_tps_pkg::FOUR - sq;
			res_q <= '0;
			one_q <= pi_tps_pkg::ONE_INIT;
		end
		// digit-by-digit square root, one result bit per cycle
		if (cmd.root_step) begin
			if (d_q >= cand) begin
				d_q   <= d_q - cand;
				res_q <= (res_q >> 1) + one_q;
			end else begin
				res_q <= res_q >> 1;
			end
			one_q <= one_q >> 2;
		end
		if (cmd.save_left || cmd.acc) begin
			yl_q <= root;
		end
		if (cmd.area) begin
			prod_q <= {{(pi_tps_pkg::P_W-pi_tps_pkg::Y_W-1){1'b0}}, ysum}
				* {{(pi_tps_pkg::P_W-pi_tps_pkg::H_W){1'b0}}, quo_q};
		end
		if (cmd.acc) begin
			sum_q <= (tot > (pi_tps_pkg::A_W+1)'(pi_tps_pkg::SUM_MAX))
				? pi_tps_pkg::SUM_MAX : tot[pi_tps_pkg::SUM_W-1:0];
		end
		if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_q.partial_sum <= err_q ? '0 : sum_q;
			out_q.range_error <= err_q;
		end
	end

	assign status.in_err = (in_data.step_count == '0)
		|| (32'(in_data.step_count) > 32'(MAX_STEPS))
		|| (in_data.first_index > in_data.end_index)
		|| (in_data.end_index > in_data.step_count);
	assign status.at_end = (idx_q == end_q);
	assign out_data      = out_q;
endmodule

FILE: verif/tb.sv
// testbench for the pi trapezoid partial sum core: directed table, random requests, bit-exact predictor
`timescale 1ns / 1ps

module tb;
	localparam int MAX_N = 65536;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		pi_tps_pkg::in_t  req;
		bit               known;
		pi_tps_pkg::out_t result;
	} row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	pi_tps_pkg::in_t  in_data;
	logic out_valid;
	logic out_ready;
	pi_tps_pkg::out_t out_data;

	pi_tps_pkg::out_t pending_sums[$];
	bit     failed;
	bit     busy_idle;
	bit     hold_out;
	longint cycles;

	pi_trapezoid_partial_sum_core #(.MAX_STEPS(MAX_N)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// floor(sqrt(4 - x^2)) with FRAC_BITS fraction bits
	function automatic logic [63:0] curve_height(logic [63:0] x);
		logic [127:0] d;
		logic [127:0] t;
		logic [63:0]  r;
		d = (128'(1) << (2 * pi_tps_pkg::FRAC_BITS + 2)) - 128'(x) * 128'(x);
		r = '0;
		for (int b = pi_tps_pkg::FRAC_BITS + 1; b >= 0; b--) begin
			t = 128'(r | (64'(1) << b));
			if (t * t <= d)
				r = t[63:0];
		end
		return r;
	endfunction

	function automatic pi_tps_pkg::out_t trapezoid_sum(pi_tps_pkg::in_t req);
		pi_tps_pkg::out_t o;
		logic [63:0]  n, lo, hi, h, yl, yr;
		logic [127:0] p;
		logic [127:0] acc;
		n  = 64'(req.step_count);
		lo = 64'(req.first_index);
		hi = 64'(req.end_index);
		o.partial_sum = '0;
		o.range_error = 1'b0;
		if (n == 0 || n > MAX_N || lo > hi || hi > n) begin
			o.range_error = 1'b1;
			return o;
		end
		h   = (64'(1) << (pi_tps_pkg::FRAC_BITS + 1)) / n;
		yl  = curve_height(lo * h);
		acc = '0;
		for (logic [63:0] i = lo; i < hi; i++) begin
			yr  = curve_height((i + 1) * h);
			p   = 128'(yl + yr) * 128'(h);
			acc = acc + (p >> (pi_tps_pkg::FRAC_BITS + 1));
			yl  = yr;
		end
		o.partial_sum = (acc > 128'(pi_tps_pkg::SUM_MAX)) ? pi_tps_pkg::SUM_MAX
			: acc[pi_tps_pkg::SUM_W-1:0];
		return o;
	endfunction

	function automatic pi_tps_pkg::in_t mk(int n, int lo, int hi);
		pi_tps_pkg::in_t r;
		r.step_count  = pi_tps_pkg::IDX_W'(n);
		r.first_index = pi_tps_pkg::IDX_W'(lo);
		r.end_index   = pi_tps_pkg::IDX_W'(hi);
		return r;
	endfunction

	function automatic row_t err_row(int n, int lo, int hi);
		row_t r;
		r.req    = mk(n, lo, hi);
		r.known  = 1'b1;
		r.result = '{partial_sum: '0, range_error: 1'b1};
		return r;
	endfunction

	function automatic row_t zero_row(int n, int lo, int hi);
		row_t r;
		r.req    = mk(n, lo, hi);
		r.known  = 1'b1;
		r.result = '{partial_sum: '0, range_error: 1'b0};
		return r;
	endfunction

	function automatic row_t calc_row(int n, int lo, int hi);
		row_t r;
		r.req    = mk(n, lo, hi);
		r.known  = 1'b0;
		r.result = '0;
		return r;
	endfunction

	// well-formed request with a short range most of the time
	function automatic pi_tps_pkg::in_t random_request();
		int n, lo, len, span;
		case ($urandom_range(0, 3))
			0: n = $urandom_range(1, 16);
			1: n = $urandom_range(1, 1024);
			default: n = $urandom_range(1, MAX_N);
		endcase
		lo   = $urandom_range(0, n);
		span = ($urandom_range(0, 49) == 0) ? 1500 : 24;
		len  = $urandom_range(0, (n - lo < span) ? n - lo : span);
		return mk(n, lo, lo + len);
	endfunction

	task automatic offer(pi_tps_pkg::in_t req, pi_tps_pkg::out_t result);
		int gap;
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (!in_ready);
		pending_sums.push_back(result);
		gap = 0;
		if (busy_idle && $urandom_range(0, 99) < 33)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			in_data  <= pi_tps_pkg::in_t'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		while (pending_sums.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		row_t dir_rows[$];
		pi_tps_pkg::in_t req;
		in_valid  = 1'b0;
		in_data   = '0;
		arst_n    = 1'b0;
		failed    = 1'b0;
		busy_idle = 1'b1;
		hold_out  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows.push_back(err_row(0, 0, 0));
		dir_rows.push_back(err_row(MAX_N + 1, 0, 1));
		dir_rows.push_back(err_row(131071, 131071, 131071));
		dir_rows.push_back(err_row(10, 5, 4));
		dir_rows.push_back(err_row(10, 0, 11));
		dir_rows.push_back(err_row(MAX_N, 0, MAX_N + 1));
		dir_rows.push_back(err_row(1, 1, 0));
		dir_rows.push_back(zero_row(1, 0, 0));
		dir_rows.push_back(zero_row(MAX_N, MAX_N, MAX_N));
		dir_rows.push_back(zero_row(77, 33, 33));
		dir_rows.push_back(calc_row(1, 0, 1));
		dir_rows.push_back(calc_row(2, 0, 2));
		dir_rows.push_back(calc_row(2, 1, 2));
		dir_rows.push_back(calc_row(3, 0, 3));
		dir_rows.push_back(calc_row(MAX_N, MAX_N - 1, MAX_N));
		dir_rows.push_back(calc_row(MAX_N, 0, 20));
		dir_rows.push_back(calc_row(MAX_N, 43690, 43712));
		dir_rows.push_back(calc_row(65535, 65530, 65535));
		dir_rows.push_back(calc_row(100, 0, 100));
		dir_rows.push_back(calc_row(4096, 2047, 2049));

		foreach (dir_rows[k]) begin
			// one-shot request for the long result hold-off
			hold_out <= (k == 8);
			offer(dir_rows[k].req,
				dir_rows[k].known ? dir_rows[k].result : trapezoid_sum(dir_rows[k].req));
		end
		hold_out <= 1'b0;

		for (int k = 0; k < 100; k++) begin
			busy_idle = !(k >= 60 && k < 80);
			if (k == 50) begin
				in_valid <= 1'b0;
				drain();
			end
			if ($urandom_range(0, 4) == 0) begin
				req = pi_tps_pkg::in_t'({$urandom, $urandom});
				// keep raw requests that pass the range check short
				if (req.first_index <= req.end_index
					&& req.end_index - req.first_index > pi_tps_pkg::IDX_W'(24))
					req.end_index = req.first_index + pi_tps_pkg::IDX_W'(24);
			end else
				req = random_request();
			offer(req, trapezoid_sum(req));
		end
		in_valid <= 1'b0;
		drain();
		repeat (50) @(posedge clk);
		if (!failed)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// result side: random back-pressure plus one long hold-off
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				for (stall = 0; stall < 400; stall++)
					@(posedge clk);
				while (hold_out)
					@(posedge clk);
			end
			out_ready <= !(busy_idle && $urandom_range(0, 99) < 33);
		end
	end

	// compare each transaction against the oldest expectation
	always @(posedge clk) begin
		pi_tps_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				$display("%0t: unexpected result sum=%h err=%b", $time,
					out_data.partial_sum, out_data.range_error);
				failed = 1'b1;
			end else begin
				want = pending_sums.pop_front();
				if (out_data.partial_sum !== want.partial_sum) begin
					$display("%0t: partial_sum expected %h actual %h", $time,
						want.partial_sum, out_data.partial_sum);
					failed = 1'b1;
				end
				if (out_data.range_error !== want.range_error) begin
					$display("%0t: range_error expected %b actual %b", $time,
						want.range_error, out_data.range_error);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end
endmodule
